FILE: design/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

FILE: design/smi_pkg.sv
`timescale 1ns / 1ps
package smi_pkg;

   // Configuration register geometry
   localparam int PRE_W      = 6;
   localparam int TRL_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PREAMBLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRAILER  = 2'd1;

   // Reset values
   localparam logic [PRE_W-1:0] PRE_RESET = 6'd35;
   localparam logic [TRL_W-1:0] TRL_RESET = 4'd4;

   // Fixed frame fields: start, opcode, turnaround (two bits each)
   localparam int HDR_BITS = 4;
   localparam int TA_BITS  = 2;

   typedef struct packed {
      logic [PRE_W-1:0] preamble_length;
      logic [TRL_W-1:0] trailer_length;
   } cfg_type;

   typedef struct packed {
      logic drive_bit;
      logic drive_enable;
      logic busy_res;
      logic done_res;
   } line_ctl_type;

endpackage

FILE: design/smi_req_if.sv
`timescale 1ns / 1ps
interface smi_req_if #(
   parameter int ADDR_BITS = 10,
   parameter int DATA_BITS = 32
);
   logic                 valid;
   logic                 ready;
   logic                 start_req;
   logic                 op;
   logic [ADDR_BITS-1:0] mgmt_address;
   logic [DATA_BITS-1:0] write_data;
   logic                 data_in;

   modport source (output valid, start_req, op, mgmt_address, write_data, data_in,
                   input ready);
   modport sink   (input valid, start_req, op, mgmt_address, write_data, data_in,
                   output ready);
endinterface

FILE: design/smi_rsp_if.sv
`timescale 1ns / 1ps
interface smi_rsp_if #(
   parameter int DATA_BITS = 32
);
   logic                 valid;
   logic                 ready;
   logic                 drive_bit;
   logic                 drive_enable;
   logic                 busy_res;
   logic                 done_res;
   logic [DATA_BITS-1:0] read_data;

   modport source (output valid, drive_bit, drive_enable, busy_res, done_res, read_data,
                   input ready);
   modport sink   (input valid, drive_bit, drive_enable, busy_res, done_res, read_data,
                   output ready);
endinterface

FILE: design/smi_csr_if.sv
`timescale 1ns / 1ps
interface smi_csr_if;
   import smi_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/smi_register_access_master_unit.sv
`timescale 1ns / 1ps
// channel   | dir | handshake      | payload
// ----------+-----+----------------+---------------------------------------------
// req_ch    | in  | valid / ready  | start_req, op, mgmt_address, write_data, data_in
// rsp_ch    | out | valid / ready  | drive_bit, drive_enable, busy_res, done_res,
//           |     |                | read_data
// csr_ch    | in  | valid / ready  | index, data (0 preamble_length, 1 trailer_length)
//
// One request per clock while the response register drains; each request is one bit
// period of the management frame and yields exactly one response, held in that register.
// The response register alone sets the rate: req_ch.ready is high whenever the
// response register is empty or is drained this cycle.
// Reset is synchronous, active high: clears frame state, loads preamble 35 and
// trailer 4, empties the response register. csr_ch is always ready.
// A stalled response holds its value; requests stall only behind it.
module smi_register_access_master_unit import smi_pkg::*; #(
   parameter int ADDR_BITS = 10,
   parameter int DATA_BITS = 32
) (
   input  logic      clock,
   input  logic      reset,
   smi_req_if.sink   req_ch,
   smi_rsp_if.source rsp_ch,
   smi_csr_if.sink   csr_ch
);
   cfg_type              cfg;
   line_ctl_type         ctl;
   logic [DATA_BITS-1:0] read_data;
   logic                 can_take;
   logic                 accept;

   // advance the frame only on an accepted request
   assign req_ch.ready = can_take;
   assign accept       = req_ch.valid && can_take;

   smi_csr_regs u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   // bit-period decode and field select
   smi_frame_seq #(
      .ADDR_BITS (ADDR_BITS),
      .DATA_BITS (DATA_BITS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .start_req    (req_ch.start_req),
      .op           (req_ch.op),
      .mgmt_address (req_ch.mgmt_address),
      .write_data   (req_ch.write_data),
      .data_in      (req_ch.data_in),
      .cfg          (cfg),
      .ctl          (ctl),
      .read_data    (read_data)
   );

   // hold the result until the sink takes it
   smi_rsp_stage #(
      .DATA_BITS (DATA_BITS)
   ) u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .ctl       (ctl),
      .read_data (read_data),
      .can_take  (can_take),
      .rsp_ch    (rsp_ch)
   );
endmodule

FILE: design/smi_csr_regs.sv
`timescale 1ns / 1ps
module smi_csr_regs import smi_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   smi_csr_if.sink   csr_ch,
   output cfg_type   cfg
);
   cfg_type cfg_ff, cfg_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_PREAMBLE: cfg_in.preamble_length = csr_ch.data[PRE_W-1:0];
            CSR_TRAILER:  cfg_in.trailer_length  = csr_ch.data[TRL_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.preamble_length <= PRE_RESET;
         cfg_ff.trailer_length  <= TRL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

FILE: design/smi_frame_seq.sv
`timescale 1ns / 1ps
module smi_frame_seq import smi_pkg::*; #(
   parameter int ADDR_BITS = 10,
   parameter int DATA_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 start_req,
   input  logic                 op,
   input  logic [ADDR_BITS-1:0] mgmt_address,
   input  logic [DATA_BITS-1:0] write_data,
   input  logic                 data_in,
   input  cfg_type              cfg,
   output line_ctl_type         ctl,
   output logic [DATA_BITS-1:0] read_data
);
   localparam int MAX_TOTAL = (2**PRE_W - 1) + HDR_BITS + ADDR_BITS + TA_BITS + DATA_BITS
                              + (2**TRL_W - 1);
   localparam int POS_W = $clog2(MAX_TOTAL + 1);
   localparam int A_SEL_W = $clog2(ADDR_BITS);
   localparam int D_SEL_W = $clog2(DATA_BITS);
   localparam logic [POS_W-1:0] Q_ADDR = POS_W'(HDR_BITS);
   localparam logic [POS_W-1:0] Q_TA   = POS_W'(HDR_BITS + ADDR_BITS);
   localparam logic [POS_W-1:0] Q_DATA = POS_W'(HDR_BITS + ADDR_BITS + TA_BITS);
   localparam logic [POS_W-1:0] Q_END  = POS_W'(HDR_BITS + ADDR_BITS + TA_BITS + DATA_BITS);
   // offsets of the last address bit and last data bit; bit index = offset - q
   localparam logic [POS_W-1:0] A_TOP  = POS_W'(HDR_BITS + ADDR_BITS - 1);
   localparam logic [POS_W-1:0] D_TOP  = POS_W'(HDR_BITS + ADDR_BITS + TA_BITS + DATA_BITS - 1);

   logic                 active_ff, active_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic                 is_read_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [DATA_BITS-1:0] data_ff;
   logic [DATA_BITS-1:0] inc_ff, inc_in;

   logic                 cur_active, cur_read, in_pre, last;
   logic [ADDR_BITS-1:0] cur_addr;
   logic [DATA_BITS-1:0] cur_data, cur_inc;
   logic [POS_W-1:0]     cur_pos, pre_ext, q, total, pos_next;
   logic [A_SEL_W-1:0]   a_sel;
   logic [D_SEL_W-1:0]   d_sel;
   logic                 bit_val, en_val;

   always_comb begin
      cur_active = active_ff || start_req;
      cur_read   = active_ff ? is_read_ff : op;
      cur_addr   = active_ff ? addr_ff    : mgmt_address;
      cur_data   = active_ff ? data_ff    : write_data;
      cur_inc    = active_ff ? inc_ff     : '0;
      cur_pos    = active_ff ? pos_ff     : '0;

      pre_ext  = POS_W'(cfg.preamble_length);
      in_pre   = cur_pos < pre_ext;
      q        = cur_pos - pre_ext;
      total    = pre_ext + Q_END + POS_W'(cfg.trailer_length);
      pos_next = cur_pos + POS_W'(1);
      last     = pos_next >= total;
      a_sel    = A_SEL_W'(A_TOP - q);
      d_sel    = D_SEL_W'(D_TOP - q);

      bit_val = 1'b0;
      en_val  = 1'b0;
      inc_in  = cur_inc;

      if (in_pre) begin
         bit_val = 1'b1;
         en_val  = 1'b1;
      end else if (q < POS_W'(2)) begin
         // start bits 0,1
         bit_val = q[0];
         en_val  = 1'b1;
      end else if (q < Q_ADDR) begin
         // opcode: write 0,1 / read 1,0
         bit_val = cur_read ^ q[0];
         en_val  = 1'b1;
      end else if (q < Q_TA) begin
         // address MSB first, picked by position
         bit_val = cur_addr[a_sel];
         en_val  = 1'b1;
      end else if (q < Q_DATA) begin
         // turnaround: write drives 1,0, read releases
         en_val  = !cur_read;
         bit_val = !cur_read && (q == Q_TA);
      end else if (q < Q_END) begin
         if (cur_read) begin
            inc_in = {cur_inc[DATA_BITS-2:0], data_in};
         end else begin
            bit_val = cur_data[d_sel];
            en_val  = 1'b1;
         end
      end

      active_in = active_ff;
      pos_in    = pos_ff;
      if (accept && cur_active) begin
         active_in = !last;
         pos_in    = last ? '0 : pos_next;
      end

      ctl.drive_bit    = cur_active && bit_val;
      ctl.drive_enable = cur_active && en_val;
      ctl.busy_res     = cur_active;
      ctl.done_res     = cur_active && last;
      read_data        = (cur_active && last && cur_read) ? inc_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pos_ff    <= '0;
      end else begin
         active_ff <= active_in;
         pos_ff    <= pos_in;
      end
      if (accept && cur_active) begin
         is_read_ff <= cur_read;
         addr_ff    <= cur_addr;
         data_ff    <= cur_data;
         inc_ff     <= inc_in;
      end
   end
endmodule

FILE: design/smi_rsp_stage.sv
`timescale 1ns / 1ps
module smi_rsp_stage import smi_pkg::*; #(
   parameter int DATA_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  line_ctl_type         ctl,
   input  logic [DATA_BITS-1:0] read_data,
   output logic                 can_take,
   smi_rsp_if.source            rsp_ch
);
   logic                 valid_ff;
   line_ctl_type         ctl_ff;
   logic [DATA_BITS-1:0] rd_ff;

   // free slot, or the held result leaves this cycle
   assign can_take = !valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         valid_ff <= 1'b0;
      end
      if (load) begin
         ctl_ff <= ctl;
         rd_ff  <= read_data;
      end
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.drive_bit    = ctl_ff.drive_bit;
   assign rsp_ch.drive_enable = ctl_ff.drive_enable;
   assign rsp_ch.busy_res     = ctl_ff.busy_res;
   assign rsp_ch.done_res     = ctl_ff.done_res;
   assign rsp_ch.read_data    = rd_ff;
endmodule

FILE: design/smi_chk.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module smi_chk #(
   parameter int DATA_BITS = 32
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 drive_bit,
   input logic                 drive_enable,
   input logic                 busy_res,
   input logic                 done_res,
   input logic [DATA_BITS-1:0] read_data
);
   `ASSERT_IMPLY(a_done_busy, clock, reset, rsp_valid && done_res, busy_res)
   `ASSERT_IMPLY(a_drive_busy, clock, reset, rsp_valid && drive_enable, busy_res)
   `ASSERT_IMPLY(a_release_low, clock, reset, rsp_valid && !drive_enable, !drive_bit)
   `ASSERT_IMPLY(a_rdata_done, clock, reset, rsp_valid && !done_res, read_data == '0)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(read_data))
endmodule

bind smi_register_access_master_unit smi_chk #(
   .DATA_BITS (DATA_BITS)
) u_chk (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .drive_bit    (rsp_ch.drive_bit),
   .drive_enable (rsp_ch.drive_enable),
   .busy_res     (rsp_ch.busy_res),
   .done_res     (rsp_ch.done_res),
   .read_data    (rsp_ch.read_data)
);
